// File: src/psfp_pkg.sv
// Package: shared constants, types and the sample conversion for the FIFO player.
`default_nettype none
package psfp_pkg;

  // Ring geometry; one entry always stays unused
  localparam int FIFO_DEPTH = 4096;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FREE_W     = PTR_W + 1;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int TIME_W   = 32;
  localparam int THRESH_W = 12;
  localparam int SPACE_W  = 12;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd1024;

  // Input kind codes
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_TICK,
    OP_FLUSH,
    OP_NONE
  } op_t;

  // Classified beat passed from front to back
  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
    logic [TIME_W-1:0] now;
  } op_item_t;

  // Clear the sign bit if set, else invert all bits, then rotate right by two
  function automatic logic [BYTE_W-1:0] to_port(input logic [BYTE_W-1:0] s);
    logic [BYTE_W-1:0] b;
    b = s[7] ? {1'b0, s[6:0]} : ~s;
    return {b[1:0], b[7:2]};
  endfunction

endpackage
`default_nettype wire

// File: src/psfp_in_if.sv
// Interface: input channel carrying kind, sample byte and time stamp.
`default_nettype none
interface psfp_in_if;
  logic                         valid;
  logic                         ready;
  logic [psfp_pkg::KIND_W-1:0]  kind;
  logic [psfp_pkg::BYTE_W-1:0]  data_byte;
  logic [psfp_pkg::TIME_W-1:0]  now_us;

  modport source (output valid, kind, data_byte, now_us, input ready);
  modport sink   (input valid, kind, data_byte, now_us, output ready);
endinterface
`default_nettype wire

// File: src/psfp_out_if.sv
// Interface: result channel carrying port byte, interval and ring status.
`default_nettype none
interface psfp_out_if;
  logic                          valid;
  logic                          ready;
  logic [psfp_pkg::BYTE_W-1:0]   port_byte;
  logic                          port_valid;
  logic [psfp_pkg::TIME_W-1:0]   interval_us;
  logic                          interval_valid;
  logic                          write_accepted;
  logic [psfp_pkg::SPACE_W-1:0]  free_space;
  logic                          space_ready;
  logic                          drained;

  modport source (output valid, port_byte, port_valid, interval_us, interval_valid,
                  write_accepted, free_space, space_ready, drained, input ready);
  modport sink   (input valid, port_byte, port_valid, interval_us, interval_valid,
                  write_accepted, free_space, space_ready, drained, output ready);
endinterface
`default_nettype wire

// File: src/psfp_front.sv
// Front: accepts input beats and classifies them into operations.
`default_nettype none
module psfp_front (
  psfp_in_if.sink              in_chan,
  output logic                 push_valid,
  input  logic                 push_ready,
  output psfp_pkg::op_item_t   push_item
);

  // Decode kind; fields that do not apply are cleared
  always_comb begin
    push_item.data = '0;
    push_item.now  = '0;
    unique case (in_chan.kind)
      psfp_pkg::KIND_WRITE: begin
        push_item.op   = psfp_pkg::OP_WRITE;
        push_item.data = in_chan.data_byte;
      end
      psfp_pkg::KIND_TICK: begin
        push_item.op  = psfp_pkg::OP_TICK;
        push_item.now = in_chan.now_us;
      end
      psfp_pkg::KIND_FLUSH: begin
        push_item.op = psfp_pkg::OP_FLUSH;
      end
      default: begin
        push_item.op = psfp_pkg::OP_NONE;
      end
    endcase
  end

  assign push_valid    = in_chan.valid;
  assign in_chan.ready = push_ready;

endmodule
`default_nettype wire

// File: src/psfp_queue.sv
// Queue: short FIFO of classified operations between front and back.
`default_nettype none
module psfp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  psfp_pkg::op_item_t   push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output psfp_pkg::op_item_t   pop_item
);

  psfp_pkg::op_item_t                 slots_r [psfp_pkg::Q_DEPTH];
  logic [psfp_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [psfp_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [psfp_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;
  logic                               do_push, do_pop;

  assign push_ready = (cnt_r != psfp_pkg::QCNT_W'(psfp_pkg::Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == psfp_pkg::QPTR_W'(psfp_pkg::Q_DEPTH - 1)) ? '0
                 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == psfp_pkg::QPTR_W'(psfp_pkg::Q_DEPTH - 1)) ? '0
                 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Slot storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// File: src/psfp_back.sv
// Back: ring pointers, sample memory, tick timing and the result register.
`default_nettype none
module psfp_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [psfp_pkg::THRESH_W-1:0]   cfg_wdata,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  psfp_pkg::op_item_t              pop_item,
  psfp_out_if.source                      out_chan
);

  localparam int PW = psfp_pkg::PTR_W;
  localparam int FW = psfp_pkg::FREE_W;

  logic [psfp_pkg::BYTE_W-1:0]    mem [psfp_pkg::FIFO_DEPTH];
  logic [psfp_pkg::BYTE_W-1:0]    rdata_r;

  logic [PW-1:0]                  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [psfp_pkg::TIME_W-1:0]    last_r, last_nxt;
  logic [psfp_pkg::THRESH_W-1:0]  thresh_r;
  logic                           out_valid_r, out_valid_nxt;

  // Result payload registers
  logic                           port_valid_r, port_valid_nxt;
  logic [psfp_pkg::TIME_W-1:0]    interval_r, interval_nxt;
  logic                           interval_valid_r, interval_valid_nxt;
  logic                           accepted_r, accepted_nxt;
  logic [psfp_pkg::SPACE_W-1:0]   free_r, free_nxt;
  logic                           space_ready_r, space_ready_nxt;
  logic                           drained_r, drained_nxt;

  logic                           fire, empty_now, full_now;
  logic [FW-1:0]                  free_calc;
  logic [31:0]                    free_wide;

  assign pop_ready = !out_valid_r || out_chan.ready;
  assign fire      = pop_valid && pop_ready;
  assign empty_now = (wp_r == rp_r);

  function automatic logic [PW-1:0] next_index(input logic [PW-1:0] p);
    return (p == PW'(psfp_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Full when advancing the write pointer would meet the read pointer
  assign full_now = (next_index(wp_r) == rp_r);

  // Execute one operation
  always_comb begin
    wp_nxt             = wp_r;
    rp_nxt             = rp_r;
    last_nxt           = last_r;
    port_valid_nxt     = 1'b0;
    interval_nxt       = '0;
    interval_valid_nxt = 1'b0;
    accepted_nxt       = 1'b0;
    if (fire) begin
      unique case (pop_item.op)
        psfp_pkg::OP_WRITE: begin
          if (!full_now) begin
            wp_nxt       = next_index(wp_r);
            accepted_nxt = 1'b1;
          end
        end
        psfp_pkg::OP_TICK: begin
          if (!empty_now) begin
            port_valid_nxt = 1'b1;
            rp_nxt         = next_index(rp_r);
          end else begin
            interval_nxt       = pop_item.now - last_r;
            interval_valid_nxt = 1'b1;
            last_nxt           = pop_item.now;
          end
        end
        psfp_pkg::OP_FLUSH: begin
          wp_nxt = rp_r;
        end
        psfp_pkg::OP_NONE: begin
        end
      endcase
    end
  end

  // Status after the step
  always_comb begin
    if (rp_nxt > wp_nxt) begin
      free_calc = FW'(rp_nxt) - FW'(wp_nxt) - 1'b1;
    end else begin
      free_calc = FW'(rp_nxt) + FW'(psfp_pkg::FIFO_DEPTH) - FW'(wp_nxt) - 1'b1;
    end
    free_wide       = 32'(free_calc);
    free_nxt        = free_wide[psfp_pkg::SPACE_W-1:0];
    space_ready_nxt = (free_wide > 32'(thresh_r));
    drained_nxt     = (wp_nxt == rp_nxt);
  end

  // Output handshake
  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      last_r      <= '0;
      thresh_r    <= psfp_pkg::THRESH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
    end
  end

  // Result payload, held while the sink stalls
  always_ff @(posedge clk) begin
    if (fire) begin
      port_valid_r     <= port_valid_nxt;
      interval_r       <= interval_nxt;
      interval_valid_r <= interval_valid_nxt;
      accepted_r       <= accepted_nxt;
      free_r           <= free_nxt;
      space_ready_r    <= space_ready_nxt;
      drained_r        <= drained_nxt;
    end
  end

  // Sample memory: one write or one registered read per beat
  always_ff @(posedge clk) begin
    if (fire && pop_item.op == psfp_pkg::OP_WRITE && !full_now) begin
      mem[wp_r] <= pop_item.data;
    end
    if (fire && pop_item.op == psfp_pkg::OP_TICK && !empty_now) begin
      rdata_r <= mem[rp_r];
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.port_byte      = port_valid_r ? psfp_pkg::to_port(rdata_r) : '0;
  assign out_chan.port_valid     = port_valid_r;
  assign out_chan.interval_us    = interval_r;
  assign out_chan.interval_valid = interval_valid_r;
  assign out_chan.write_accepted = accepted_r;
  assign out_chan.free_space     = free_r;
  assign out_chan.space_ready    = space_ready_r;
  assign out_chan.drained        = drained_r;

endmodule
`default_nettype wire

// File: src/port_sample_fifo_player_top.sv
// Top level: byte ring buffer player with front decode, op queue and back execution.
//
//  channel   | direction | handshake       | payload
//  ----------+-----------+-----------------+------------------------------------------
//  in_chan   | in        | valid/ready     | kind, data_byte, now_us
//  out_chan  | out       | valid/ready     | port_byte, port_valid, interval_us,
//            |           |                 | interval_valid, write_accepted,
//            |           |                 | free_space, space_ready, drained
//  cfg_*     | in        | write enable    | space_threshold (12 bit)
//
// One beat per cycle sustained while out_chan does not stall; a beat is stored in
// the two-entry op queue and executes in the back, which registers its result beat.
// The back retires one op per cycle, unless out_chan stalls, against the single-port
// sample memory. Reset (synchronous, rst_n low) clears pointers and tick time, sets
// the threshold to 1024 and does not clear the sample memory. An output stall backs
// up the queue, then in_chan.
`default_nettype none
module port_sample_fifo_player_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [psfp_pkg::THRESH_W-1:0]   cfg_wdata,
  psfp_in_if.sink                         in_chan,
  psfp_out_if.source                      out_chan
);

  logic                 push_valid, push_ready;
  logic                 pop_valid, pop_ready;
  psfp_pkg::op_item_t   push_item, pop_item;

  psfp_front u_front (
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  psfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  psfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire
